[design/prnc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_pkg
// Shared widths, register indexes and types of the periodic neighbour counter.
// ----------------------------------------------------------------------------
package prnc_pkg;

    // coordinate and count widths
    localparam int COORD_BITS = 24;
    localparam int COUNT_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int RSQ_BITS   = 48;

    // configuration port
    localparam int CFG_DATA_BITS = (COORD_BITS > RSQ_BITS) ? COORD_BITS : RSQ_BITS;
    localparam int CFG_IDX_BITS  = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LENGTH = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQ  = 1'd1;
    localparam logic [COORD_BITS-1:0]   BOX_RESET      = COORD_BITS'(24'hFFFFFF);

    // datapath widths
    localparam int DIFF_BITS = COORD_BITS + 2;
    localparam int WRAP_BITS = COORD_BITS + 1;
    localparam int SQ_BITS   = 2 * COORD_BITS;
    localparam int SUM_BITS  = 2 * COORD_BITS + 2;
    localparam int CMP_BITS  = (SUM_BITS > RSQ_BITS) ? SUM_BITS : RSQ_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // work queue between front and back
    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    // per-item flags carried down the front pipeline
    typedef struct packed {
        logic has;
        logic start;
        logic last;
    } t_flags;

    // classified item handed to the back end
    typedef struct packed {
        logic hit;
        logic start;
        logic last;
    } t_work;

endpackage

[design/prnc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_front
// Five-stage pipeline: differences, periodic wrap, squares, sum, radius test.
// Flow control by credits so the pipeline itself never stalls.
// ----------------------------------------------------------------------------
module prnc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_box_length,
    input  logic [prnc_pkg::RSQ_BITS-1:0]   i_radius_sq,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_query_x,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_query_y,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_query_z,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_cand_x,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_cand_y,
    input  logic [prnc_pkg::COORD_BITS-1:0] i_cand_z,
    input  logic                            i_has_candidate,
    input  logic                            i_start_query,
    input  logic                            i_last_candidate,
    input  logic                            i_credit_return,
    output logic                            o_push,
    output prnc_pkg::t_work                 o_entry
);
    import prnc_pkg::*;

    logic                        accept;
    logic [COORD_BITS-1:0]       a_q [3];
    logic [COORD_BITS-1:0]       a_c [3];
    logic [Q_CNT_BITS-1:0]       r_credit;
    logic [Q_CNT_BITS-1:0]       n_credit;
    logic [3:0]                  r_vld;
    t_flags                      r_fl [4];
    logic signed [DIFF_BITS-1:0] r_d [3];
    logic signed [WRAP_BITS-1:0] r_w [3];
    logic signed [WRAP_BITS-1:0] n_w [3];
    logic [SQ_BITS-1:0]          r_sq [3];
    logic [SQ_BITS-1:0]          n_sq [3];
    logic [SUM_BITS-1:0]         r_sum;
    logic                        r_push;
    t_work                       r_entry;

    assign a_q[0] = i_query_x;
    assign a_q[1] = i_query_y;
    assign a_q[2] = i_query_z;
    assign a_c[0] = i_cand_x;
    assign a_c[1] = i_cand_y;
    assign a_c[2] = i_cand_z;

    // credits cover every item in the pipeline and in the queue
    assign o_stall = (r_credit == '0);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_credit = r_credit;
        case ({accept, i_credit_return})
            2'b10:   n_credit = r_credit - Q_CNT_BITS'(1);
            2'b01:   n_credit = r_credit + Q_CNT_BITS'(1);
            default: n_credit = r_credit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= Q_CNT_BITS'(Q_DEPTH);
            r_vld    <= '0;
            r_push   <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r_vld    <= {r_vld[2:0], accept};
            r_push   <= r_vld[3];
        end
    end

    // periodic wrap, applied once per axis
    always_comb begin
        logic signed [DIFF_BITS:0]   d2;
        logic signed [DIFF_BITS:0]   lw;
        logic signed [DIFF_BITS-1:0] lx;
        logic signed [DIFF_BITS-1:0] dm;
        logic signed [DIFF_BITS-1:0] dp;
        lx = signed'({2'b00, i_box_length});
        lw = signed'({3'b000, i_box_length});
        for (int a = 0; a < 3; a++) begin
            d2 = signed'({r_d[a], 1'b0});
            dm = r_d[a] - lx;
            dp = r_d[a] + lx;
            if (d2 > lw) begin
                n_w[a] = dm[WRAP_BITS-1:0];
            end else if (d2 < -lw) begin
                n_w[a] = dp[WRAP_BITS-1:0];
            end else begin
                n_w[a] = r_d[a][WRAP_BITS-1:0];
            end
        end
    end

    // squares, one multiplier per axis
    always_comb begin
        logic signed [2*WRAP_BITS-1:0] prod;
        for (int a = 0; a < 3; a++) begin
            prod    = r_w[a] * r_w[a];
            n_sq[a] = prod[SQ_BITS-1:0];
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_d[a]  <= signed'({2'b00, a_q[a]}) - signed'({2'b00, a_c[a]});
            r_w[a]  <= n_w[a];
            r_sq[a] <= n_sq[a];
        end
        r_fl[0] <= '{has: i_has_candidate, start: i_start_query, last: i_last_candidate};
        r_fl[1] <= r_fl[0];
        r_fl[2] <= r_fl[1];
        r_fl[3] <= r_fl[2];
        r_sum   <= SUM_BITS'(r_sq[0]) + SUM_BITS'(r_sq[1]) + SUM_BITS'(r_sq[2]);
        r_entry.hit   <= r_fl[3].has && (CMP_BITS'(r_sum) <= CMP_BITS'(i_radius_sq));
        r_entry.start <= r_fl[3].start;
        r_entry.last  <= r_fl[3].last;
    end

    assign o_push  = r_push;
    assign o_entry = r_entry;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= Q_CNT_BITS'(Q_DEPTH))
        else $error("credit count above queue depth");
`endif

endmodule

[design/prnc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module prnc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  prnc_pkg::t_work i_entry,
    input  logic            i_pop,
    output logic            o_nonempty,
    output prnc_pkg::t_work o_entry
);
    import prnc_pkg::*;

    t_work                 r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr;
    logic [Q_PTR_BITS-1:0] r_rd;
    logic [Q_CNT_BITS-1:0] r_cnt;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_BITS'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_BITS'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_nonempty = (r_cnt != '0);
    assign o_entry    = r_mem[r_rd];

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != Q_CNT_BITS'(Q_DEPTH)) || i_pop)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("pop from empty queue");
`endif

endmodule

[design/prnc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prnc_back
// Running neighbour count and the registered result output.
// ----------------------------------------------------------------------------
module prnc_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_nonempty,
    input  prnc_pkg::t_work               i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [prnc_pkg::OUT_BITS-1:0] o_neighbour_count
);
    import prnc_pkg::*;

    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;
    logic [COUNT_BITS-1:0] cur;
    logic                  r_out_valid;
    logic [COUNT_BITS-1:0] r_out_count;
    logic                  out_free;
    logic [63:0]           out_wide;

    // an item that emits needs the output register free
    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = i_nonempty && (!i_entry.last || out_free);

    // clear, then count with saturation
    always_comb begin
        cur     = i_entry.start ? '0 : r_count;
        n_count = cur;
        if (i_entry.hit && (cur != COUNT_MAX)) begin
            n_count = cur + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_count <= n_count;
            end
            if (o_pop && i_entry.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.last) begin
            r_out_count <= n_count;
        end
    end

    assign out_wide          = 64'(r_out_count);
    assign o_valid           = r_out_valid;
    assign o_neighbour_count = out_wide[OUT_BITS-1:0];

`ifndef SYNTHESIS
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_entry.last) |-> out_free)
        else $error("result overwritten while stalled");
    a_count_kept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> $stable(r_count))
        else $error("count changed without transaction");
`endif

endmodule

[design/periodic_radius_neighbor_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_radius_neighbor_counter
// Counts candidate points within a squared radius of a query point, using the
// minimum-image wrap in a cubic periodic box, and emits the count per query.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | i_valid / o_stall    | query xyz, cand xyz, has, start, last
//  result   | o_valid / i_stall    | o_neighbour_count
//  config   | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  one transaction per cycle sustained while o_stall is low; o_valid rises after the
//  transaction that closes the query has passed the first front stage (loaded at the
//  accepting edge), four more front stages, the queue slot, then the output register
//  the front runs on credits for an 8-entry work queue, so input stall rises
//  only when the queue and pipeline hold 8 items, i.e. when results back up
//  reset is synchronous, active low: count zero, box all ones, radius zero
// ----------------------------------------------------------------------------
module periodic_radius_neighbor_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [prnc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [prnc_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_query_x,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_query_y,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_query_z,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_cand_x,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_cand_y,
    input  logic [prnc_pkg::COORD_BITS-1:0]    i_cand_z,
    input  logic                               i_has_candidate,
    input  logic                               i_start_query,
    input  logic                               i_last_candidate,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [prnc_pkg::OUT_BITS-1:0]      o_neighbour_count
);
    import prnc_pkg::*;

    logic [COORD_BITS-1:0] r_box_length;
    logic [RSQ_BITS-1:0]   r_radius_sq;
    logic                  push;
    t_work                 push_entry;
    logic                  pop;
    logic                  nonempty;
    t_work                 head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_length <= BOX_RESET;
            r_radius_sq  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BOX_LENGTH: r_box_length <= i_cfg_data[COORD_BITS-1:0];
                REG_RADIUS_SQ:  r_radius_sq  <= i_cfg_data[RSQ_BITS-1:0];
                default:        r_box_length <= r_box_length;
            endcase
        end
    end

    // classification pipeline
    prnc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_box_length     (r_box_length),
        .i_radius_sq      (r_radius_sq),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_query_x        (i_query_x),
        .i_query_y        (i_query_y),
        .i_query_z        (i_query_z),
        .i_cand_x         (i_cand_x),
        .i_cand_y         (i_cand_y),
        .i_cand_z         (i_cand_z),
        .i_has_candidate  (i_has_candidate),
        .i_start_query    (i_start_query),
        .i_last_candidate (i_last_candidate),
        .i_credit_return  (pop),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    // work queue
    prnc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_entry    (push_entry),
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_entry    (head)
    );

    // counting and result output
    prnc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_nonempty        (nonempty),
        .i_entry           (head),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_neighbour_count (o_neighbour_count)
    );

endmodule
